[sv/sine_range_reduce_polynomial_unit_macros.svh]
// ---------------------------------------------------------------------------
// sine_range_reduce_polynomial_unit_macros: assertion macros
// Clocked implication checks shared by the sine unit modules.
// ---------------------------------------------------------------------------
`ifndef SINE_RANGE_REDUCE_POLYNOMIAL_UNIT_MACROS_SVH
`define SINE_RANGE_REDUCE_POLYNOMIAL_UNIT_MACROS_SVH
// implication check under clock and async reset
`define SRP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
// next-cycle implication check
`define SRP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

[sv/srp_pkg.sv]
// ---------------------------------------------------------------------------
// srp_pkg: shared types and constants for the sine unit
// Formats, polynomial coefficients and the front-to-back queue entry.
// ---------------------------------------------------------------------------
package srp_pkg;
	localparam int AngleW = 32;
	localparam int OutFrac = 30;
	localparam int NEven = 10;
	localparam int QDepth = 4;
	localparam int QPtrW = 2;
	// pi in Q52, 2^52 * pi rounded
	localparam logic [54:0] PiQ52 = 55'd14148475504056881;
	localparam logic [54:0] HalfPiQ52 = 55'd7074237752028440;
	localparam int Stages = NEven - 1;

	// queue entry: reduced and centered angle plus tags
	typedef struct packed {
		logic signed [31:0] c;
		logic odd;
		logic last;
	} srp_item_t;

	function automatic logic signed [31:0] coef(input int i);
		case (i)
			0: coef = 32'sd1073741824;
			1: coef = -32'sd536870912;
			2: coef = 32'sd44739243;
			3: coef = -32'sd1491308;
			4: coef = 32'sd26630;
			5: coef = -32'sd296;
			6: coef = 32'sd2;
			default: coef = 32'sd0;
		endcase
	endfunction
endpackage

[sv/srp_front.sv]
// ---------------------------------------------------------------------------
// srp_front: range reduction
// Reduces angle modulo pi in a short pipeline, one quotient bit per stage.
// ---------------------------------------------------------------------------
module srp_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] angle,
	input  logic last_in,
	output logic out_valid,
	input  logic out_ready,
	output srp_pkg::srp_item_t item
);
	import srp_pkg::*;
	// |angle| < 2^7 rad => |a|/pi < 41, quotient in [-41,40]; 7 bits of quotient
	// after the bias of 64*pi the dividend is below 2^61, signed width 62
	localparam int DivSteps = 7;
	localparam int RW = 62;

	logic [DivSteps:0] vld;
	logic signed [RW-1:0] rem [DivSteps+1];
	logic [DivSteps-1:0] quo [DivSteps+1];
	logic lst [DivSteps+1];
	logic adv;
	logic signed [RW-1:0] cfull;
	logic signed [RW-1:0] crnd;

	assign adv = !vld[DivSteps] || out_ready;
	assign in_ready = adv;

	// stage 0: shift angle to Q52 and bias so remainder is nonneg
	// a + 64*pi >= 0 always; bias parity even so k parity unchanged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[DivSteps-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem[0] <= RW'({{(RW-60){angle[31]}}, angle, 28'd0}) + RW'(PiQ52) * RW'(64);
			quo[0] <= '0;
			lst[0] <= last_in;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar s = 0; s < DivSteps; s++) begin : g_div
		logic signed [RW-1:0] d;
		logic signed [RW-1:0] t;
		assign d = RW'(PiQ52) <<< (DivSteps - 1 - s);
		assign t = rem[s] - d;
		always_ff @(posedge clk) begin
			if (adv) begin
				rem[s+1] <= t[RW-1] ? rem[s] : t;
				quo[s+1] <= {quo[s][DivSteps-2:0], !t[RW-1]};
				lst[s+1] <= lst[s];
			end
		end
	end

	// center and round to Q30
	assign cfull = rem[DivSteps] - RW'(HalfPiQ52);
	assign crnd = (cfull + RW'(1 << 21)) >>> 22;
	assign out_valid = vld[DivSteps];
	assign item.c = crnd[31:0];
	assign item.odd = quo[DivSteps][0];
	assign item.last = lst[DivSteps];

	`include "sine_range_reduce_polynomial_unit_macros.svh"
	`SRP_ASSERT_IMP(a_rem_range, vld[DivSteps], rem[DivSteps] < RW'(PiQ52))
	`SRP_ASSERT_IMP(a_rem_pos, vld[DivSteps], !rem[DivSteps][RW-1])
	`SRP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
endmodule

[sv/srp_queue.sv]
// ---------------------------------------------------------------------------
// srp_queue: small queue between front and back
// Register-based FIFO of reduced items.
// ---------------------------------------------------------------------------
module srp_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  srp_pkg::srp_item_t wr_item,
	output logic rd_valid,
	input  logic rd_ready,
	output srp_pkg::srp_item_t rd_item
);
	import srp_pkg::*;
	srp_item_t mem_q [QDepth];
	logic [QPtrW-1:0] wp_q, rp_q;
	logic [QPtrW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (QPtrW+1)'(QDepth);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	`include "sine_range_reduce_polynomial_unit_macros.svh"
	`SRP_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= (QPtrW+1)'(QDepth))
	`SRP_ASSERT_NEXT(a_cnt_inc, wr && !rd, cnt_q == $past(cnt_q) + 1'b1)
	`SRP_ASSERT_NEXT(a_cnt_dec, rd && !wr, cnt_q == $past(cnt_q) - 1'b1)
endmodule

[sv/srp_back.sv]
// ---------------------------------------------------------------------------
// srp_back: polynomial evaluation
// Squares c, then one Horner step per stage, sign and saturation at the end.
// ---------------------------------------------------------------------------
module srp_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  srp_pkg::srp_item_t item,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] sine,
	output logic last_out
);
	import srp_pkg::*;
	localparam int NS = Stages + 2;

	logic [NS-1:0] vld;
	logic adv;
	logic signed [63:0] sq;
	// z reaches (pi/2)^2 in Q30, above 2^31
	logic signed [32:0] z [NS-1];
	logic signed [33:0] acc [NS-1];
	logic odd [NS-1];
	logic lst [NS-1];
	logic signed [34:0] res;

	assign adv = !vld[NS-1] || out_ready;
	assign in_ready = adv;
	assign sq = item.c * item.c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[NS-2:0], in_valid};
		end
	end

	// stage 0: z = round(c*c) in Q30
	always_ff @(posedge clk) begin
		if (adv) begin
			z[0] <= 33'((sq + 64'sd536870912) >>> 30);
			acc[0] <= 34'(coef(NEven - 1));
			odd[0] <= item.odd;
			lst[0] <= item.last;
		end
	end

	// Horner steps, highest coefficient first
	for (genvar s = 0; s < Stages; s++) begin : g_horner
		logic signed [66:0] p;
		assign p = acc[s] * z[s];
		always_ff @(posedge clk) begin
			if (adv) begin
				acc[s+1] <= 34'((p + 67'sd536870912) >>> 30) + 34'(coef(NEven - 2 - s));
				z[s+1] <= z[s];
				odd[s+1] <= odd[s];
				lst[s+1] <= lst[s];
			end
		end
	end

	// sign and saturate into output register
	assign res = odd[NS-2] ? -35'(acc[NS-2]) : 35'(acc[NS-2]);
	always_ff @(posedge clk) begin
		if (adv) begin
			if (res > 35'sd1073741824) sine <= 32'sd1073741824;
			else if (res < -35'sd1073741824) sine <= -32'sd1073741824;
			else sine <= res[31:0];
			last_out <= lst[NS-2];
		end
	end
	assign out_valid = vld[NS-1];

	`include "sine_range_reduce_polynomial_unit_macros.svh"
	`SRP_ASSERT_IMP(a_sat, out_valid, sine <= 32'sd1073741824 && sine >= -32'sd1073741824)
	`SRP_ASSERT_IMP(a_zpos, vld[0], !z[0][32])
	`SRP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(sine))
endmodule

[sv/sine_range_reduce_polynomial_unit.sv]
// ---------------------------------------------------------------------------
// sine_range_reduce_polynomial_unit: fixed-point sine
// Q7.24 angle in, Q1.30 sine out, one angle accepted per clock unless back-pressured.
// ---------------------------------------------------------------------------
// Accepts one angle every cycle while not back-pressured and returns one result per angle in order.
// An angle passes through the one-bit-per-stage reduction modulo pi, then
// through the queue, then through the squaring, nine Horner steps and the
// saturating output register.
// A 4-entry queue between reduction and polynomial absorbs output stalls.
module sine_range_reduce_polynomial_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [31:0] s_axis_tdata, // [31:0] angle
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // [31:0] sine
	output logic m_axis_tlast
);
	import srp_pkg::*;
	srp_item_t f_item, q_item;
	logic f_valid, f_ready, q_valid, q_ready;

	srp_front u_front (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.angle(s_axis_tdata), .last_in(s_axis_tlast), .out_valid(f_valid),
		.out_ready(f_ready), .item(f_item));
	srp_queue u_queue (.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_item(f_item), .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item));
	srp_back u_back (.clk, .arst_n, .in_valid(q_valid), .in_ready(q_ready), .item(q_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .sine(m_axis_tdata),
		.last_out(m_axis_tlast));
endmodule

[tb/sine_checker.sv]
// ---------------------------------------------------------------------------
// sine_checker: result predictor and scoreboard for the sine unit
// Watches both stream channels, computes the expected sine of every accepted
// angle and compares each output transaction against the oldest expectation.
// ---------------------------------------------------------------------------
module sine_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [31:0] s_axis_tdata, // [31:0] angle
	input  logic s_axis_tlast,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [31:0] m_axis_tdata, // [31:0] sine
	input  logic m_axis_tlast,
	output int fails,
	output int pending,
	output int checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] sine;
		logic last;
	} sine_result_t;

	// pi in Q60, reduced to Q52 with rounding
	localparam logic [63:0] PiQ60 = 64'd3622009729038561421;
	localparam longint PiQ52 = longint'((PiQ60 + 64'd128) >> 8);
	localparam longint HalfPiQ52 = longint'((PiQ60 + 64'd256) >> 9);
	localparam int EvenTerms = 10;

	// cosine series coefficients, Q30, 1/(2i)! with alternating sign
	localparam longint CosCoef [EvenTerms] = '{
		64'sd1073741824, -64'sd536870912, 64'sd44739243, -64'sd1491308,
		64'sd26630, -64'sd296, 64'sd2, 64'sd0, 64'sd0, 64'sd0
	};

	sine_result_t expected_sines[$];

	function automatic longint round_half_up(longint x, int s);
		return (x + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] sine_of_angle(logic signed [31:0] angle);
		longint scaled, quot, rem, cen, sq, acc;
		scaled = longint'(angle) * (longint'(1) << 28);
		quot = scaled / PiQ52;
		rem = scaled % PiQ52;
		if (rem < 0) begin
			rem += PiQ52;
			quot -= 1;
		end
		cen = round_half_up(rem - HalfPiQ52, 22);
		sq = round_half_up(cen * cen, 30);
		acc = CosCoef[EvenTerms-1];
		for (int i = EvenTerms - 2; i >= 0; i--)
			acc = round_half_up(acc * sq, 30) + CosCoef[i];
		if (quot[0])
			acc = -acc;
		// overshoot clamps to plus or minus one
		if (acc > (longint'(1) << 30))
			acc = longint'(1) << 30;
		if (acc < -(longint'(1) << 30))
			acc = -(longint'(1) << 30);
		return acc[31:0];
	endfunction

	assign pending = expected_sines.size();

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		sine_result_t want;
		logic bad;
		if (!arst_n) begin
			fails <= 0;
			checked <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_sines.push_back('{sine_of_angle(s_axis_tdata), s_axis_tlast});
			if (m_axis_tvalid && m_axis_tready) begin
				checked <= checked + 1;
				if (expected_sines.size() == 0) begin
					$error("unexpected result: sine %0d", $signed(m_axis_tdata));
					fails <= fails + 1;
				end else begin
					want = expected_sines.pop_front();
					bad = 1'b0;
					if (want.sine !== m_axis_tdata) begin
						$error("sine mismatch: expected %0d, actual %0d",
							want.sine, $signed(m_axis_tdata));
						bad = 1'b1;
					end
					if (want.last !== m_axis_tlast) begin
						$error("last mismatch: expected %0b, actual %0b",
							want.last, m_axis_tlast);
						bad = 1'b1;
					end
					if (bad)
						fails <= fails + 1;
				end
			end
		end
	end
endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the sine unit
// Directed angles around multiples of pi/2 and the range ends, then random
// angles in bursts, with a stalling receiver and one long back-pressure hold.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomAngles = 400;
	localparam int IdleLimit = 3000;
	localparam int LongHold = 80;
	localparam logic signed [31:0] PiQ24 = 32'sd52707179;
	localparam logic signed [31:0] HalfPiQ24 = 32'sd26353589;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic m_axis_tlast;
	int fails, pending, checked;
	int idle_cycles = 0;
	int burst_left = 0;

	always #5 clk = ~clk;

	sine_range_reduce_polynomial_unit dut (.*);
	sine_checker u_checker (.*);

	// one input transaction; in two of three cases a gap of idle cycles when a burst runs out
	task automatic send_angle(logic [31:0] angle, logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 2) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= angle;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// receiver: phases of full rate, random stalls and one long hold
	initial begin
		int mode;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		repeat (150) begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(8, 40)) begin
				@(posedge clk);
				case (mode)
					0: begin
						m_axis_tready <= 1'b1;
					end
					1: begin
						m_axis_tready <= 1'($urandom_range(0, 1));
					end
					default: begin
						m_axis_tready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
			if (!held && checked > 60) begin
				held = 1'b1;
				@(posedge clk);
				m_axis_tready <= 1'b0;
				repeat (LongHold) @(posedge clk);
			end
		end
		@(posedge clk);
		m_axis_tready <= 1'b1;
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [31:0] angle;
		logic signed [31:0] corner [20];
		corner = '{32'sd0, 32'sd1, -32'sd1, 32'h7fffffff, 32'h80000000,
			HalfPiQ24, -HalfPiQ24, PiQ24, -PiQ24, PiQ24 + 1, PiQ24 - 1,
			2 * PiQ24, 3 * HalfPiQ24, HalfPiQ24 + 1, HalfPiQ24 - 1,
			-3 * HalfPiQ24, 32'sd16777216, -32'sd16777216, 32'h55555555,
			32'haaaaaaaa};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, last toggling
		foreach (corner[i])
			send_angle(corner[i], i[0]);

		// random: mostly small angles, some full 32-bit patterns
		for (int i = 0; i < RandomAngles; i++) begin
			if ($urandom_range(0, 3) == 0)
				angle = $urandom;
			else
				angle = $urandom_range(0, 32'd268435456) - 32'd134217728;
			send_angle(angle, 1'($urandom_range(0, 1)));
		end
		s_axis_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (40) @(posedge clk);
		$display("tb: %0d angles checked, directed corners plus random angles", checked);
		$display("tb: receiver stalls and one long hold applied, %0d mismatches", fails);
		if (fails == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

[filelist.f]
+incdir+sv
sv/srp_pkg.sv
sv/srp_front.sv
sv/srp_queue.sv
sv/srp_back.sv
sv/sine_range_reduce_polynomial_unit.sv
tb/sine_checker.sv
tb/testbench.sv
